// File: rtl/lottery_scheduler_assert.svh
// assertion macros shared by the scheduler rtl
`ifndef LOTTERY_SCHEDULER_ASSERT_SVH
`define LOTTERY_SCHEDULER_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define LSCH_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lottery scheduler check failed");
// next-cycle implication, sampled on clk, off during reset
`define LSCH_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lottery scheduler check failed");
`else
`define LSCH_ASSERT_IMP(name, ante, cons)
`define LSCH_ASSERT_NXT(name, ante, cons)
`endif

`endif

// File: rtl/lsch_pkg.sv
`timescale 1ns / 1ps
package lsch_pkg;

  // defaults and fixed widths
  localparam int LSCH_SLOTS  = 16;
  localparam int RAND_W      = 31;
  localparam logic [15:0] QUANTUM_RST = 16'd3;

  // request codes
  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_LOAD  = 2'd1;
  localparam logic [1:0] REQ_ROUND = 2'd2;

  // one slot of the task table
  typedef struct packed {
    logic [15:0] arrival;
    logic [15:0] remaining;
    logic [7:0]  tickets;
  } lsch_entry_t;

  // table control from the sequencer
  typedef struct packed {
    logic clear;
    logic load;
    logic we;
    logic mark;
  } lsch_tbl_ctl_t;

  // one result item
  typedef struct packed {
    logic        idle;
    logic        all_done;
    logic [3:0]  chosen_slot;
    logic [31:0] start_time;
    logic [15:0] run_length;
    logic        finished;
    logic [31:0] completion_time;
    logic [31:0] turnaround_time;
    logic        first_run;
    logic [31:0] response_time;
  } lsch_result_t;

  // sequencer states
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN1 = 7'b0000010,
    S_MOD   = 7'b0000100,
    S_SCAN2 = 7'b0001000,
    S_READ  = 7'b0010000,
    S_WB    = 7'b0100000,
    S_EMIT  = 7'b1000000
  } lsch_state_t;

endpackage

// File: rtl/lsch_if.sv
`timescale 1ns / 1ps
// request channel
interface lsch_in_if import lsch_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [3:0]        slot;
  logic [15:0]       arrival;
  logic [15:0]       burst;
  logic [7:0]        tickets;
  logic [RAND_W-1:0] random_value;

  modport source (output valid, req_type, slot, arrival, burst, tickets, random_value,
                  input ready);
  modport sink   (input valid, req_type, slot, arrival, burst, tickets, random_value,
                  output ready);
endinterface

// result channel
interface lsch_out_if ();
  logic        valid;
  logic        ready;
  logic        idle;
  logic        all_done;
  logic [3:0]  chosen_slot;
  logic [31:0] start_time;
  logic [15:0] run_length;
  logic        finished;
  logic [31:0] completion_time;
  logic [31:0] turnaround_time;
  logic        first_run;
  logic [31:0] response_time;

  modport source (output valid, idle, all_done, chosen_slot, start_time, run_length,
                  finished, completion_time, turnaround_time, first_run, response_time,
                  input ready);
  modport sink   (input valid, idle, all_done, chosen_slot, start_time, run_length,
                  finished, completion_time, turnaround_time, first_run, response_time,
                  output ready);
endinterface

// quantum write channel
interface lsch_cfg_if ();
  logic        valid;
  logic        ready;
  logic [15:0] quantum;

  modport source (output valid, quantum, input ready);
  modport sink   (input valid, quantum, output ready);
endinterface

// File: rtl/lottery_scheduler.sv
`timescale 1ns / 1ps
// channel  | dir | handshake            | carries
// in_ch    | in  | valid / ready        | req_type slot arrival burst tickets random_value
// out_ch   | out | valid / ready        | one round result
// cfg_ch   | in  | valid / ready        | quantum
//
// a round makes two passes over the slot memory with a bit-serial modulo of the random
// word by the ticket sum between them, then read, write-back and emit. with no eligible
// task the first pass goes straight to emit; with a zero ticket sum it goes to read.
// synchronous active-low reset clears valid and started flags and the clock, quantum is 3.
// a waiting result holds the next round in emit until the output register is free.
`include "lottery_scheduler_assert.svh"
module lottery_scheduler import lsch_pkg::*; #(
  parameter int SLOTS = LSCH_SLOTS
) (
  input  logic       clk,
  input  logic       rst_n,
  lsch_in_if.sink    in_ch,
  lsch_out_if.source out_ch,
  lsch_cfg_if.sink   cfg_ch
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int SW = $clog2(SLOTS * 255 + 1);

  lsch_state_t       st_r, st_nxt;
  logic [31:0]       time_r, time_nxt;
  logic [15:0]       quantum_r, quantum_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              pv_r, pv_nxt;
  logic [IW-1:0]     pidx_r, pidx_nxt;
  logic [SW-1:0]     sum_r, sum_nxt;
  logic [SW-1:0]     cum_r, cum_nxt;
  logic              any_r, any_nxt;
  logic [IW-1:0]     first_r, first_nxt;
  logic [CW-1:0]     unfin_r, unfin_nxt;
  logic              found_r, found_nxt;
  logic [IW-1:0]     chosen_r, chosen_nxt;
  logic [SW-1:0]     win_r, win_nxt;
  logic [RAND_W-1:0] rand_r, rand_nxt;
  logic [15:0]       carr_r, carr_nxt;
  lsch_result_t      res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  lsch_result_t      out_r, out_nxt;

  lsch_tbl_ctl_t     tbl_ctl;
  logic [IW-1:0]     tbl_waddr;
  lsch_entry_t       tbl_wdata;
  logic [IW-1:0]     tbl_raddr;
  lsch_entry_t       rdata;
  logic [SLOTS-1:0]  valid_flags;
  logic [SLOTS-1:0]  started_flags;

  logic              mod_start;
  logic              mod_done;
  logic [SW-1:0]     mod_rem;

  logic              scan_end;
  logic              elig;
  logic              unfin_hit;
  logic [SW-1:0]     cum_add;
  logic [15:0]       q_eff;
  logic [15:0]       run;
  logic [15:0]       new_rem;

  logic [31:0]       out_end;
  logic              idle_end;
  logic [31:0]       idle_tick;

  lsch_table #(.SLOTS(SLOTS), .IW(IW)) u_table (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (tbl_ctl),
    .waddr         (tbl_waddr),
    .wdata         (tbl_wdata),
    .raddr         (tbl_raddr),
    .rdata         (rdata),
    .valid_flags   (valid_flags),
    .started_flags (started_flags)
  );

  lsch_mod #(.SW(SW)) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (rand_r),
    .divisor   (sum_r),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // per-slot tests on the data read last cycle
  assign scan_end  = (cnt_r == CW'(SLOTS)) && !pv_r;
  assign unfin_hit = pv_r && valid_flags[pidx_r] && (rdata.remaining != 16'd0);
  assign elig      = unfin_hit && ({16'd0, rdata.arrival} <= time_r);
  assign cum_add   = cum_r + SW'(rdata.tickets);

  // run length of the winner
  assign q_eff   = (quantum_r == 16'd0) ? 16'd1 : quantum_r;
  assign run     = (q_eff < rdata.remaining) ? q_eff : rdata.remaining;
  assign new_rem = rdata.remaining - run;

  // sequencer
  always_comb begin
    st_nxt        = st_r;
    time_nxt      = time_r;
    quantum_nxt   = quantum_r;
    cnt_nxt       = cnt_r;
    pv_nxt        = 1'b0;
    pidx_nxt      = pidx_r;
    sum_nxt       = sum_r;
    cum_nxt       = cum_r;
    any_nxt       = any_r;
    first_nxt     = first_r;
    unfin_nxt     = unfin_r;
    found_nxt     = found_r;
    chosen_nxt    = chosen_r;
    win_nxt       = win_r;
    rand_nxt      = rand_r;
    carr_nxt      = carr_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_nxt       = out_r;
    tbl_ctl       = '0;
    tbl_waddr     = chosen_r;
    tbl_wdata     = '{arrival: rdata.arrival, remaining: new_rem, tickets: rdata.tickets};
    tbl_raddr     = cnt_r[IW-1:0];
    mod_start     = 1'b0;

    if (cfg_ch.valid) begin
      quantum_nxt = cfg_ch.quantum;
    end

    // slot read issue during both passes
    if ((st_r == S_SCAN1 || st_r == S_SCAN2) && cnt_r < CW'(SLOTS)) begin
      cnt_nxt  = cnt_r + CW'(1);
      pv_nxt   = 1'b1;
      pidx_nxt = cnt_r[IW-1:0];
    end

    unique case (st_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          rand_nxt = in_ch.random_value;
          unique case (in_ch.req_type)
            REQ_CLEAR: begin
              tbl_ctl.clear = 1'b1;
              time_nxt      = '0;
            end
            REQ_LOAD: begin
              if (32'(in_ch.slot) < SLOTS) begin
                tbl_ctl.load = 1'b1;
                tbl_ctl.we   = 1'b1;
                tbl_waddr    = IW'(in_ch.slot);
                tbl_wdata    = '{arrival: in_ch.arrival, remaining: in_ch.burst,
                                 tickets: in_ch.tickets};
              end
            end
            REQ_ROUND: begin
              st_nxt    = S_SCAN1;
              cnt_nxt   = '0;
              sum_nxt   = '0;
              any_nxt   = 1'b0;
              first_nxt = '0;
              unfin_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      // first pass: ticket sum, first eligible slot, unfinished count
      S_SCAN1: begin
        if (elig) begin
          sum_nxt = sum_r + SW'(rdata.tickets);
          if (!any_r) begin
            first_nxt = pidx_r;
          end
          any_nxt = 1'b1;
        end
        if (unfin_hit) begin
          unfin_nxt = unfin_r + CW'(1);
        end
        if (scan_end) begin
          if (!any_r) begin
            res_nxt          = '0;
            res_nxt.idle     = 1'b1;
            res_nxt.all_done = (unfin_r == '0);
            time_nxt         = time_r + 32'(unfin_r != '0);
            st_nxt           = S_EMIT;
          end else if (sum_r == '0) begin
            chosen_nxt = first_r;
            st_nxt     = S_READ;
          end else begin
            mod_start = 1'b1;
            st_nxt    = S_MOD;
          end
        end
      end
      S_MOD: begin
        if (mod_done) begin
          win_nxt    = mod_rem;
          cnt_nxt    = '0;
          cum_nxt    = '0;
          found_nxt  = 1'b0;
          chosen_nxt = first_r;
          st_nxt     = S_SCAN2;
        end
      end
      // second pass: cumulative tickets until the winning ticket
      S_SCAN2: begin
        if (elig && !found_r) begin
          cum_nxt = cum_add;
          if (win_r < cum_add) begin
            found_nxt  = 1'b1;
            chosen_nxt = pidx_r;
          end
        end
        if (scan_end) begin
          st_nxt = S_READ;
        end
      end
      S_READ: begin
        tbl_raddr = chosen_r;
        st_nxt    = S_WB;
      end
      // winner runs: write back remaining work, build the result
      S_WB: begin
        tbl_ctl.we              = 1'b1;
        tbl_ctl.mark            = 1'b1;
        time_nxt                = time_r + 32'(run);
        carr_nxt                = rdata.arrival;
        res_nxt                 = '0;
        res_nxt.chosen_slot     = 4'(chosen_r);
        res_nxt.start_time      = time_r;
        res_nxt.run_length      = run;
        res_nxt.finished        = (new_rem == 16'd0);
        res_nxt.completion_time = (new_rem == 16'd0) ? time_r + 32'(run) : 32'd0;
        res_nxt.first_run       = !started_flags[chosen_r];
        res_nxt.response_time   = started_flags[chosen_r] ? 32'd0
                                  : time_r - 32'(rdata.arrival);
        res_nxt.all_done        = ((unfin_r - CW'(new_rem == 16'd0)) == '0);
        st_nxt                  = S_EMIT;
      end
      // hand the result to the output register once it is free
      S_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_nxt                 = res_r;
          out_nxt.turnaround_time = res_r.finished
                                    ? res_r.completion_time - 32'(carr_r) : 32'd0;
          out_valid_nxt           = 1'b1;
          st_nxt                  = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      time_r      <= '0;
      quantum_r   <= QUANTUM_RST;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      time_r      <= time_nxt;
      quantum_r   <= quantum_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cnt_r    <= cnt_nxt;
    pidx_r   <= pidx_nxt;
    sum_r    <= sum_nxt;
    cum_r    <= cum_nxt;
    any_r    <= any_nxt;
    first_r  <= first_nxt;
    unfin_r  <= unfin_nxt;
    found_r  <= found_nxt;
    chosen_r <= chosen_nxt;
    win_r    <= win_nxt;
    rand_r   <= rand_nxt;
    carr_r   <= carr_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
  end

  // ports
  assign in_ch.ready            = (st_r == S_IDLE);
  assign cfg_ch.ready           = 1'b1;
  assign out_ch.valid           = out_valid_r;
  assign out_ch.idle            = out_r.idle;
  assign out_ch.all_done        = out_r.all_done;
  assign out_ch.chosen_slot     = out_r.chosen_slot;
  assign out_ch.start_time      = out_r.start_time;
  assign out_ch.run_length      = out_r.run_length;
  assign out_ch.finished        = out_r.finished;
  assign out_ch.completion_time = out_r.completion_time;
  assign out_ch.turnaround_time = out_r.turnaround_time;
  assign out_ch.first_run       = out_r.first_run;
  assign out_ch.response_time   = out_r.response_time;

  // checks
  assign out_end   = out_r.start_time + 32'(out_r.run_length);
  assign idle_end  = (st_r == S_SCAN1) && scan_end && !any_r;
  assign idle_tick = time_r + 32'(unfin_r != '0);
  `LSCH_ASSERT_IMP(a_wb_winner_live, st_r == S_WB, valid_flags[chosen_r] && (|rdata.remaining))
  `LSCH_ASSERT_IMP(a_win_below_sum, st_r == S_SCAN2, win_r < sum_r)
  `LSCH_ASSERT_IMP(a_finish_time, out_valid_r && out_r.finished, out_r.completion_time == out_end)
  `LSCH_ASSERT_NXT(a_idle_tick, idle_end, time_r == $past(idle_tick))

endmodule

// File: rtl/lsch_table.sv
`timescale 1ns / 1ps
module lsch_table import lsch_pkg::*; #(
  parameter int SLOTS = LSCH_SLOTS,
  parameter int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lsch_tbl_ctl_t     ctl,
  input  logic [IW-1:0]     waddr,
  input  lsch_entry_t       wdata,
  input  logic [IW-1:0]     raddr,
  output lsch_entry_t       rdata,
  output logic [SLOTS-1:0]  valid_flags,
  output logic [SLOTS-1:0]  started_flags
);

  lsch_entry_t      mem [SLOTS];
  logic [SLOTS-1:0] valid_r, valid_nxt;
  logic [SLOTS-1:0] started_r, started_nxt;

  // slot storage, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // valid and started flags
  always_comb begin
    valid_nxt   = valid_r;
    started_nxt = started_r;
    if (ctl.clear) begin
      valid_nxt   = '0;
      started_nxt = '0;
    end else if (ctl.load) begin
      valid_nxt[waddr]   = 1'b1;
      started_nxt[waddr] = 1'b0;
    end else if (ctl.mark) begin
      started_nxt[waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      started_r <= '0;
    end else begin
      valid_r   <= valid_nxt;
      started_r <= started_nxt;
    end
  end

  assign valid_flags   = valid_r;
  assign started_flags = started_r;

endmodule

// File: rtl/lsch_mod.sv
`timescale 1ns / 1ps
module lsch_mod import lsch_pkg::*; #(
  parameter int SW = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RAND_W-1:0] dividend,
  input  logic [SW-1:0]     divisor,
  output logic              done,
  output logic [SW-1:0]     remainder
);

  localparam int NW = $clog2(RAND_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [NW-1:0]     cnt_r, cnt_nxt;
  logic [RAND_W-1:0] dvd_r, dvd_nxt;
  logic [SW-1:0]     div_r, div_nxt;
  logic [SW-1:0]     rem_r, rem_nxt;
  logic [SW:0]       shifted;

  // restoring remainder, one dividend bit a cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    shifted  = {rem_r, dvd_r[RAND_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = NW'(RAND_W - 1);
      dvd_nxt  = dividend;
      div_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[RAND_W-2:0], 1'b0};
      if (shifted >= {1'b0, div_r}) begin
        rem_nxt = SW'(shifted - {1'b0, div_r});
      end else begin
        rem_nxt = shifted[SW-1:0];
      end
      cnt_nxt = cnt_r - NW'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule
